// ===== rtl/core/nfba_pkg.sv =====
`default_nettype none

package nfba_pkg;

  // Heap geometry
  localparam int unsigned HEAP_BYTES   = 4096;
  localparam int unsigned HEADER_BYTES = 32;
  localparam int unsigned MAX_BLOCKS   = 128;
  localparam int unsigned ALIGN_BYTES  = 8;

  // Derived widths
  localparam int unsigned AW = $clog2(HEAP_BYTES);   // byte offset
  localparam int unsigned SW = AW + 1;               // block size
  localparam int unsigned IW = $clog2(MAX_BLOCKS);   // table index
  localparam int unsigned CW = IW + 1;               // block count
  localparam int unsigned EW = AW + SW + 1;          // table entry

  // Fixed item field widths
  localparam int unsigned REQ_W    = 12;
  localparam int unsigned OFF_W    = 12;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned PROBE_W  = 8;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOFIT  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_BADOFF = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EARLY  = 3'd4;

  // One block table entry
  typedef struct packed {
    logic          free;
    logic [SW-1:0] size;
    logic [AW-1:0] start;
  } entry_t;

  localparam entry_t ENTRY_INIT = '{free: 1'b1,
                                    size: SW'(HEAP_BYTES - HEADER_BYTES),
                                    start: '0};

  // Datapath operations
  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_IDX,
    OP_NEXT_PROBE,
    OP_FREE_NEXT,
    OP_CAP,
    OP_SHUP_RD,
    OP_SHUP_WR,
    OP_WR_NEW,
    OP_ALLOC_WR,
    OP_SET_FREE,
    OP_RD_NXT,
    OP_RD_PRV,
    OP_MERGE_NXT,
    OP_MERGE_PRV,
    OP_SHDN_RD,
    OP_SHDN_WR,
    OP_DEC_CNT,
    OP_SET_CURSOR,
    OP_DONE
  } op_e;

  typedef struct packed {
    op_e                 op;
    logic [STATUS_W-1:0] status;
  } cmd_t;

  // Datapath flags back to the controller
  typedef struct packed {
    logic is_free;
    logic zero_req;
    logic started;
    logic fit;
    logic match;
    logic rd_free;
    logic split;
    logic last_idx;
    logic probes_done;
    logic ku_stop;
    logic kd_stop;
    logic idx_zero;
    logic out_free;
  } stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/nfba_ram.sv =====
`default_nettype none

module nfba_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/nfba_dp.sv =====
`default_nettype none

module nfba_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire nfba_pkg::cmd_t                   cmd_i,
  output      nfba_pkg::stat_t                  stat_o,
  input  wire logic                             in_func_i,
  input  wire logic [nfba_pkg::REQ_W-1:0]       in_req_i,
  input  wire logic [nfba_pkg::OFF_W-1:0]       in_off_i,
  output      logic                             out_valid_o,
  input  wire logic                             out_ready_i,
  output      logic [nfba_pkg::STATUS_W-1:0]    out_status_o,
  output      logic [nfba_pkg::OFF_W-1:0]       out_offset_o,
  output      logic [nfba_pkg::PROBE_W-1:0]     out_probes_o
);
  import nfba_pkg::*;

  logic          func_q;
  logic [SW-1:0] need_q;
  logic [AW-1:0] off_q;
  logic [IW-1:0] idx_q;
  logic [CW-1:0] cnt_q;
  logic [IW-1:0] cursor_q;
  logic          started_q;
  logic [CW-1:0] p_q;
  logic [CW-1:0] k_q;
  entry_t        cur_q;
  logic          e0_wr_q;
  logic          rd0_q;
  logic          valid_q;
  logic [STATUS_W-1:0] status_q;
  logic [OFF_W-1:0]    offset_q;
  logic [PROBE_W-1:0]  probes_q;

  logic          we;
  logic [IW-1:0] waddr;
  entry_t        wdata;
  logic          re;
  logic [IW-1:0] raddr;
  logic [EW-1:0] ram_rdata;
  entry_t        rd_e;

  logic [SW-1:0] rem;
  logic          split;
  logic [CW-1:0] idx_p1;
  logic [CW-1:0] cnt_new;
  logic [SW-1:0] merge_nxt_sz;
  logic [SW-1:0] merge_prv_sz;
  logic [SW-1:0] need_in;

  nfba_ram #(
    .WIDTH(EW),
    .DEPTH(MAX_BLOCKS)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  // Entry 0 reads as its reset value until first written
  assign rd_e = (rd0_q && !e0_wr_q) ? ENTRY_INIT : entry_t'(ram_rdata);

  // Split and merge arithmetic
  assign rem          = cur_q.size - need_q;
  assign split        = (rem > SW'(HEADER_BYTES + ALIGN_BYTES)) && (cnt_q < CW'(MAX_BLOCKS));
  assign idx_p1       = CW'(idx_q) + CW'(1);
  assign cnt_new      = cnt_q + CW'(split);
  assign merge_nxt_sz = cur_q.size + SW'(HEADER_BYTES) + rd_e.size;
  assign merge_prv_sz = rd_e.size + SW'(HEADER_BYTES) + cur_q.size;
  assign need_in      = (SW'(in_req_i) + SW'(ALIGN_BYTES - 1)) & ~SW'(ALIGN_BYTES - 1);

  // Flags to the controller
  always_comb begin
    stat_o.is_free     = func_q;
    stat_o.zero_req    = (need_q == '0);
    stat_o.started     = started_q;
    stat_o.fit         = rd_e.free && (rd_e.size >= need_q);
    stat_o.match       = ((SW'(rd_e.start) + SW'(HEADER_BYTES)) == SW'(off_q));
    stat_o.rd_free     = rd_e.free;
    stat_o.split       = split;
    stat_o.last_idx    = (idx_p1 >= cnt_q);
    stat_o.probes_done = (p_q >= cnt_q);
    stat_o.ku_stop     = (k_q <= idx_p1);
    stat_o.kd_stop     = ((k_q + CW'(1)) >= cnt_q);
    stat_o.idx_zero    = (idx_q == '0);
    stat_o.out_free    = !valid_q || out_ready_i;
  end

  // Table port selection
  always_comb begin
    we    = 1'b0;
    waddr = idx_q;
    wdata = cur_q;
    re    = 1'b0;
    raddr = idx_q;
    case (cmd_i.op)
      OP_RD_IDX: begin
        re = 1'b1;
      end
      OP_SHUP_RD: begin
        re    = 1'b1;
        raddr = k_q[IW-1:0] - IW'(1);
      end
      OP_SHUP_WR: begin
        we    = 1'b1;
        waddr = k_q[IW-1:0];
        wdata = rd_e;
      end
      OP_WR_NEW: begin
        we    = 1'b1;
        waddr = idx_q + IW'(1);
        wdata = '{free: 1'b1,
                  size: rem - SW'(HEADER_BYTES),
                  start: AW'(SW'(cur_q.start) + SW'(HEADER_BYTES) + need_q)};
      end
      OP_ALLOC_WR: begin
        we    = 1'b1;
        wdata = '{free: 1'b0, size: split ? need_q : cur_q.size, start: cur_q.start};
      end
      OP_SET_FREE: begin
        we         = 1'b1;
        wdata.free = 1'b1;
      end
      OP_RD_NXT: begin
        re    = 1'b1;
        raddr = idx_q + IW'(1);
      end
      OP_RD_PRV: begin
        re    = 1'b1;
        raddr = idx_q - IW'(1);
      end
      OP_MERGE_NXT: begin
        we    = 1'b1;
        wdata = '{free: 1'b1, size: merge_nxt_sz, start: cur_q.start};
      end
      OP_MERGE_PRV: begin
        we    = 1'b1;
        waddr = idx_q - IW'(1);
        wdata = '{free: 1'b1, size: merge_prv_sz, start: rd_e.start};
      end
      OP_SHDN_RD: begin
        re    = 1'b1;
        raddr = k_q[IW-1:0] + IW'(1);
      end
      OP_SHDN_WR: begin
        we    = 1'b1;
        waddr = k_q[IW-1:0];
        wdata = rd_e;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q     <= CW'(1);
      cursor_q  <= '0;
      started_q <= 1'b0;
      e0_wr_q   <= 1'b0;
      rd0_q     <= 1'b0;
      valid_q   <= 1'b0;
    end else begin
      if (re) begin
        rd0_q <= (raddr == '0);
      end
      if (we && (waddr == '0)) begin
        e0_wr_q <= 1'b1;
      end
      // new result loads the output register, else a taken one empties it
      if (cmd_i.op == OP_DONE) begin
        valid_q <= 1'b1;
      end else if (valid_q && out_ready_i) begin
        valid_q <= 1'b0;
      end
      case (cmd_i.op)
        OP_LOAD: begin
          if (!in_func_i && (in_req_i != '0)) begin
            started_q <= 1'b1;
          end
        end
        OP_ALLOC_WR: begin
          cnt_q    <= cnt_new;
          cursor_q <= (idx_p1 < cnt_new) ? idx_p1[IW-1:0] : '0;
        end
        OP_DEC_CNT: begin
          cnt_q <= cnt_q - CW'(1);
        end
        OP_SET_CURSOR: begin
          cursor_q <= idx_q;
        end
        default: begin
          cnt_q <= cnt_q;
        end
      endcase
    end
  end

  // Working registers and result payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        func_q <= in_func_i;
        need_q <= need_in;
        off_q  <= AW'(in_off_i);
        p_q    <= CW'(1);
        idx_q  <= (!in_func_i && (CW'(cursor_q) < cnt_q)) ? cursor_q : '0;
      end
      OP_NEXT_PROBE: begin
        idx_q <= stat_o.last_idx ? '0 : idx_q + IW'(1);
        p_q   <= p_q + CW'(1);
      end
      OP_FREE_NEXT: begin
        idx_q <= idx_q + IW'(1);
      end
      OP_CAP: begin
        cur_q <= rd_e;
        k_q   <= cnt_q;
      end
      OP_SHUP_WR: begin
        k_q <= k_q - CW'(1);
      end
      OP_SET_FREE: begin
        cur_q.free <= 1'b1;
      end
      OP_MERGE_NXT: begin
        cur_q.size <= merge_nxt_sz;
        k_q        <= idx_p1;
      end
      OP_MERGE_PRV: begin
        cur_q <= '{free: 1'b1, size: merge_prv_sz, start: rd_e.start};
        k_q   <= CW'(idx_q);
        idx_q <= idx_q - IW'(1);
      end
      OP_SHDN_WR: begin
        k_q <= k_q + CW'(1);
      end
      OP_DONE: begin
        status_q <= cmd_i.status;
        if ((cmd_i.status == ST_OK) && !func_q) begin
          offset_q <= OFF_W'(SW'(cur_q.start) + SW'(HEADER_BYTES));
          probes_q <= PROBE_W'(p_q);
        end else begin
          offset_q <= '0;
          probes_q <= (cmd_i.status == ST_NOFIT) ? PROBE_W'(cnt_q) : '0;
        end
      end
      default: begin
        func_q <= func_q;
      end
    endcase
  end

  assign out_valid_o  = valid_q;
  assign out_status_o = status_q;
  assign out_offset_o = offset_q;
  assign out_probes_o = probes_q;

endmodule

`default_nettype wire

// ===== rtl/core/nfba_ctrl.sv =====
`default_nettype none

module nfba_ctrl (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output      logic            in_ready_o,
  input  wire nfba_pkg::stat_t stat_i,
  output      nfba_pkg::cmd_t  cmd_o
);
  import nfba_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_DISPATCH,
    S_A_RD,
    S_A_CHK,
    S_A_DEC,
    S_A_SU,
    S_A_SUW,
    S_A_NEW,
    S_A_WR,
    S_F_RD,
    S_F_CHK,
    S_F_SET,
    S_F_NX,
    S_F_NXC,
    S_F_SD,
    S_F_SDW,
    S_F_PV,
    S_F_PVC,
    S_F_CUR,
    S_FIN
  } state_e;

  state_e              state_q, state_d;
  logic [STATUS_W-1:0] res_q, res_d;
  logic                ret_cur_q, ret_cur_d;

  assign in_ready_o = (state_q == S_IDLE);

  // Next state and datapath command
  always_comb begin
    state_d    = state_q;
    res_d      = res_q;
    ret_cur_d  = ret_cur_q;
    cmd_o.op     = OP_NONE;
    cmd_o.status = res_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = OP_LOAD;
          state_d  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (!stat_i.is_free) begin
          if (stat_i.zero_req) begin
            res_d   = ST_ZERO;
            state_d = S_FIN;
          end else begin
            state_d = S_A_RD;
          end
        end else if (!stat_i.started) begin
          res_d   = ST_EARLY;
          state_d = S_FIN;
        end else begin
          state_d = S_F_RD;
        end
      end
      // next-fit search: read an entry, then check it
      S_A_RD: begin
        cmd_o.op = OP_RD_IDX;
        state_d  = S_A_CHK;
      end
      S_A_CHK: begin
        if (stat_i.fit) begin
          cmd_o.op = OP_CAP;
          state_d  = S_A_DEC;
        end else if (stat_i.probes_done) begin
          res_d   = ST_NOFIT;
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_NEXT_PROBE;
          state_d  = S_A_RD;
        end
      end
      S_A_DEC: begin
        state_d = stat_i.split ? S_A_SU : S_A_WR;
      end
      // open a slot after the chosen block
      S_A_SU: begin
        if (stat_i.ku_stop) begin
          state_d = S_A_NEW;
        end else begin
          cmd_o.op = OP_SHUP_RD;
          state_d  = S_A_SUW;
        end
      end
      S_A_SUW: begin
        cmd_o.op = OP_SHUP_WR;
        state_d  = S_A_SU;
      end
      S_A_NEW: begin
        cmd_o.op = OP_WR_NEW;
        state_d  = S_A_WR;
      end
      S_A_WR: begin
        cmd_o.op = OP_ALLOC_WR;
        res_d    = ST_OK;
        state_d  = S_FIN;
      end
      // linear search for the block to release
      S_F_RD: begin
        cmd_o.op = OP_RD_IDX;
        state_d  = S_F_CHK;
      end
      S_F_CHK: begin
        if (stat_i.match) begin
          cmd_o.op = OP_CAP;
          state_d  = S_F_SET;
        end else if (stat_i.last_idx) begin
          res_d   = ST_BADOFF;
          state_d = S_FIN;
        end else begin
          cmd_o.op = OP_FREE_NEXT;
          state_d  = S_F_RD;
        end
      end
      S_F_SET: begin
        cmd_o.op = OP_SET_FREE;
        state_d  = S_F_NX;
      end
      // merge with the following block
      S_F_NX: begin
        if (!stat_i.last_idx) begin
          cmd_o.op = OP_RD_NXT;
          state_d  = S_F_NXC;
        end else begin
          state_d = S_F_PV;
        end
      end
      S_F_NXC: begin
        if (stat_i.rd_free) begin
          cmd_o.op  = OP_MERGE_NXT;
          ret_cur_d = 1'b0;
          state_d   = S_F_SD;
        end else begin
          state_d = S_F_PV;
        end
      end
      // close the gap left by a merge
      S_F_SD: begin
        if (stat_i.kd_stop) begin
          cmd_o.op = OP_DEC_CNT;
          state_d  = ret_cur_q ? S_F_CUR : S_F_PV;
        end else begin
          cmd_o.op = OP_SHDN_RD;
          state_d  = S_F_SDW;
        end
      end
      S_F_SDW: begin
        cmd_o.op = OP_SHDN_WR;
        state_d  = S_F_SD;
      end
      // merge into the preceding block
      S_F_PV: begin
        if (!stat_i.idx_zero) begin
          cmd_o.op = OP_RD_PRV;
          state_d  = S_F_PVC;
        end else begin
          state_d = S_F_CUR;
        end
      end
      S_F_PVC: begin
        if (stat_i.rd_free) begin
          cmd_o.op  = OP_MERGE_PRV;
          ret_cur_d = 1'b1;
          state_d   = S_F_SD;
        end else begin
          state_d = S_F_CUR;
        end
      end
      S_F_CUR: begin
        cmd_o.op = OP_SET_CURSOR;
        res_d    = ST_OK;
        state_d  = S_FIN;
      end
      // hand over the result once the output register is free
      S_FIN: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_DONE;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      res_q     <= ST_OK;
      ret_cur_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      res_q     <= res_d;
      ret_cur_q <= ret_cur_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/next_fit_block_allocator.sv =====
// Channel   Dir  Signals                         Contents
// s_axis    in   tvalid/tready/tdata[23:0]/tuser  request: func, req_size, free_offset
// m_axis    out  tvalid/tready/tdata[23:0]        result: status, payload_offset, probe_count
//
// One item at a time; an input item is taken only while the controller is idle.
// Allocate: probes blocks in turn, then moves table entries up to open a slot on a split.
// Free: searches blocks in turn, then moves entries down on each merge.
// Worst case is set by the walk over the 128-entry block table RAM.
// Reset restores a single free block covering the whole heap; no clearing pass.
// A held result stalls only the final hand-off of the next result; no item is taken during that stall.
`default_nettype none

module next_fit_block_allocator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output      logic        s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,   // req_size[11:0], free_offset[23:12]
  input  wire logic [0:0]  s_axis_tuser_i,   // func[0]
  output      logic        m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output      logic [23:0] m_axis_tdata_o    // status[2:0], payload_offset[14:3],
                                             // probe_count[22:15], zero pad[23]
);
  import nfba_pkg::*;

  cmd_t  cmd;
  stat_t stat;
  logic [STATUS_W-1:0] out_status;
  logic [OFF_W-1:0]    out_offset;
  logic [PROBE_W-1:0]  out_probes;

  nfba_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid_i),
    .in_ready_o(s_axis_tready_o),
    .stat_i    (stat),
    .cmd_o     (cmd)
  );

  nfba_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_func_i   (s_axis_tuser_i[0]),
    .in_req_i    (s_axis_tdata_i[11:0]),
    .in_off_i    (s_axis_tdata_i[23:12]),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_status_o(out_status),
    .out_offset_o(out_offset),
    .out_probes_o(out_probes)
  );

  // Result packing
  assign m_axis_tdata_o = {1'b0, out_probes, out_offset, out_status};

endmodule

`default_nettype wire

// ===== rtl/core/nfba_chk.sv =====
`default_nettype none

module nfba_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid_i,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [23:0] m_axis_tdata_o
);
  import nfba_pkg::*;

  // A result held back stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Items are worked one at a time
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("item taken while busy");

  // Failed requests carry no offset
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2:0] != ST_OK) |-> (m_axis_tdata_o[14:3] == '0))
    else $error("offset on failed request");

  // A granted block lies past its header
  a_ok_offset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[2:0] == ST_OK) && (m_axis_tdata_o[22:15] != '0)
    |-> (m_axis_tdata_o[14:3] >= 12'(HEADER_BYTES)))
    else $error("granted offset inside a header");

endmodule

bind next_fit_block_allocator nfba_chk u_nfba_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o)
);

`default_nettype wire
